[rtl/core/caseless_substring_match_core_macros.svh]
// Assertion macros for the caseless substring match RTL.
`ifndef CASELESS_SUBSTRING_MATCH_CORE_MACROS_SVH
`define CASELESS_SUBSTRING_MATCH_CORE_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define CSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/csm_pkg.sv]
// Package of types, constants and helper functions for the caseless substring match.
`default_nettype none

package csm_pkg;

    localparam int MAX_NEEDLE = 32;
    localparam int REG_CHARS  = 32;
    localparam int ACTIVE_MAX = (MAX_NEEDLE < REG_CHARS) ? MAX_NEEDLE : REG_CHARS;
    localparam int WIN_DEPTH  = (ACTIVE_MAX > 1) ? ACTIVE_MAX - 1 : 1;
    localparam int LEN_W      = 6;
    localparam int NIDX_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTH  = 3'd0,
        REG_CHARS_A = 3'd1,
        REG_CHARS_B = 3'd2,
        REG_CHARS_C = 3'd3,
        REG_CHARS_D = 3'd4
    } cfg_reg_t;

    typedef logic [REG_CHARS-1:0][7:0] needle_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        needle_t          chars;
    } needle_cfg_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] needle_char(input needle_t n, input logic [NIDX_W-1:0] idx);
        return n[idx];
    endfunction

endpackage

`default_nettype wire

[rtl/core/caseless_substring_match_core.sv]
// Top level of the caseless substring match: window cell chain, hit tracking and result buffer.
//
//  Channel   Handshake                    Payload
//  text      text_valid / text_ready      text_byte, is_final, empty_text
//  result    result_valid / result_ready  found
//  cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One text byte is taken in every cycle while the skid register is empty; the cells compare registered bytes.
// A result is registered into the output register, or into the skid register while the output is held.
// A second result waits in a skid register, and text is held back only while that is full.
// Reset clears the configuration, the byte count, the hit flag and the valid flags of both result registers.
// Configuration writes are always taken; cfg_ready is held high.
`default_nettype none
`include "caseless_substring_match_core_macros.svh"

module caseless_substring_match_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           text_valid,
    output logic                                text_ready,
    input  wire logic [7:0]                     text_byte,
    input  wire logic                           is_final,
    input  wire logic                           empty_text,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic                                found,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [csm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csm_pkg::CFG_DATA_W-1:0] cfg_data
);

    csm_pkg::needle_cfg_t       needle_cfg;
    logic                       in_fire;
    logic                       out_fire;
    logic [7:0]                 c_fold;
    logic                       shift;
    logic                       hit;
    logic                       seen_ok;
    logic [csm_pkg::LEN_W-1:0]  last_pos;
    logic [7:0]                 win_byte   [csm_pkg::WIN_DEPTH];
    logic [csm_pkg::WIN_DEPTH-1:0] cell_match;

    logic [csm_pkg::LEN_W-1:0]  bytes_seen_reg;
    logic [csm_pkg::LEN_W-1:0]  bytes_seen_next;
    logic                       match_seen_reg;
    logic                       match_seen_next;
    logic                       res_valid;
    logic                       res_found;
    logic                       result_valid_reg;
    logic                       found_reg;
    logic                       skid_valid_reg;
    logic                       skid_found_reg;

    assign cfg_ready  = 1'b1;
    assign text_ready = !skid_valid_reg;
    assign in_fire    = text_valid && text_ready;
    assign out_fire   = result_valid_reg && result_ready;
    assign c_fold     = csm_pkg::fold(text_byte);

    csm_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .needle_cfg (needle_cfg)
    );

    for (genvar k = 0; k < csm_pkg::WIN_DEPTH; k++)
    begin : g_cell
        logic [csm_pkg::LEN_W-1:0] pos;
        logic [7:0]                prev_byte;

        assign pos = needle_cfg.len - csm_pkg::LEN_W'(k + 2);

        if (k == 0)
        begin : g_head
            assign prev_byte = c_fold;
        end
        else
        begin : g_body
            assign prev_byte = win_byte[k - 1];
        end

        csm_cell u_cell (
            .clk         (clk),
            .shift       (shift),
            .byte_in     (prev_byte),
            .needle_byte (csm_pkg::needle_char(needle_cfg.chars, pos[csm_pkg::NIDX_W-1:0])),
            .active      (needle_cfg.len > csm_pkg::LEN_W'(k + 1)),
            .byte_out    (win_byte[k]),
            .match       (cell_match[k])
        );
    end

    assign last_pos = needle_cfg.len - csm_pkg::LEN_W'(1);
    assign seen_ok  = ({1'b0, bytes_seen_reg} + (csm_pkg::LEN_W + 1)'(1))
                      >= {1'b0, needle_cfg.len};

    always_comb
    begin
        if (needle_cfg.len == '0)
        begin
            hit = 1'b1;
        end
        else
        begin
            hit = seen_ok && (&cell_match)
                  && (c_fold == csm_pkg::needle_char(needle_cfg.chars,
                                                     last_pos[csm_pkg::NIDX_W-1:0]));
        end
    end

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        match_seen_next = match_seen_reg;
        res_valid       = 1'b0;
        res_found       = 1'b0;
        shift           = 1'b0;
        if (in_fire)
        begin
            if (empty_text)
            begin
                bytes_seen_next = '0;
                match_seen_next = 1'b0;
                res_valid       = 1'b1;
                res_found       = (needle_cfg.len == '0);
            end
            else
            begin
                shift = 1'b1;
                if (bytes_seen_reg != '1)
                begin
                    bytes_seen_next = bytes_seen_reg + csm_pkg::LEN_W'(1);
                end
                match_seen_next = match_seen_reg || hit;
                if (is_final)
                begin
                    res_valid       = 1'b1;
                    res_found       = match_seen_reg || hit;
                    bytes_seen_next = '0;
                    match_seen_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            match_seen_reg <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            match_seen_reg <= match_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (out_fire || !result_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
            else
            begin
                result_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !result_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                found_reg <= skid_found_reg;
            end
            else
            begin
                found_reg <= res_found;
            end
        end
        else if (res_valid)
        begin
            skid_found_reg <= res_found;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;

    `CSM_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_reg |-> result_valid_reg, "skid full while output empty")
    `CSM_ASSERT(a_skid_holds, (skid_valid_reg && !result_ready) |=> skid_valid_reg, "skid result lost")
    `CSM_ASSERT(a_empty_clears, (in_fire && empty_text) |=> (bytes_seen_reg == '0 && !match_seen_reg), "empty marker left state")
    `CSM_ASSERT(a_hit_needs_bytes, match_seen_reg |-> (bytes_seen_reg != '0), "hit flag without bytes")

endmodule

`default_nettype wire

[rtl/core/csm_cfg_regs.sv]
// Configuration registers holding the needle, folded and with its length limited.
`default_nettype none

module csm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [csm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output csm_pkg::needle_cfg_t                  needle_cfg
);

    logic [csm_pkg::LEN_W-1:0]      len_reg;
    logic [3:0][csm_pkg::CFG_DATA_W-1:0] words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            words_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (csm_pkg::cfg_reg_t'(cfg_index))
                csm_pkg::REG_LENGTH:  len_reg      <= cfg_data[csm_pkg::LEN_W-1:0];
                csm_pkg::REG_CHARS_A: words_reg[0] <= cfg_data;
                csm_pkg::REG_CHARS_B: words_reg[1] <= cfg_data;
                csm_pkg::REG_CHARS_C: words_reg[2] <= cfg_data;
                csm_pkg::REG_CHARS_D: words_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (len_reg > csm_pkg::LEN_W'(csm_pkg::ACTIVE_MAX))
        begin
            needle_cfg.len = csm_pkg::LEN_W'(csm_pkg::ACTIVE_MAX);
        end
        else
        begin
            needle_cfg.len = len_reg;
        end
        for (int i = 0; i < csm_pkg::REG_CHARS; i++)
        begin
            needle_cfg.chars[i] = csm_pkg::fold(words_reg[i / 8][(i % 8) * 8 +: 8]);
        end
    end

endmodule

`default_nettype wire

[rtl/core/csm_cell.sv]
// One window cell: holds a folded text byte, passes it on and compares it with its needle character.
`default_nettype none

module csm_cell (
    input  wire logic       clk,
    input  wire logic       shift,
    input  wire logic [7:0] byte_in,
    input  wire logic [7:0] needle_byte,
    input  wire logic       active,
    output logic      [7:0] byte_out,
    output logic            match
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign match    = !active || (byte_reg == needle_byte);

endmodule

`default_nettype wire
